// ===== design/hct_pkg.sv =====
`timescale 1ns / 1ps

package hct_pkg;

  // Pixel store geometry; the store is addressed row * MAX_WIDTH + column.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // Input operations.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MESH = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_SCALE      = 2'd2;

  // Heights are Q16.8; a sum of up to four of them needs two more bits.
  localparam int HGT_W = 24;
  localparam int SUM_W = HGT_W + 2;

  // Division by three: multiply by ceil(2^28 / 3) and keep the bits above 28.
  localparam int DIV3_SHIFT = 28;
  localparam logic [DIV3_SHIFT-1:0] DIV3_MUL = 28'd89478486;

  // Cell corners: NW, NE, SE, SW.
  localparam logic [1:0] CORNER_NW = 2'd0;
  localparam logic [1:0] CORNER_NE = 2'd1;
  localparam logic [1:0] CORNER_SE = 2'd2;
  localparam logic [1:0] CORNER_SW = 2'd3;

  // Triangle slots of one cell, in emission order.
  localparam int TRI_COUNT = 12;
  localparam logic [3:0] TRI_TOP0 = 4'd0;
  localparam logic [3:0] TRI_TOP1 = 4'd1;
  localparam logic [3:0] TRI_N0   = 4'd2;
  localparam logic [3:0] TRI_N1   = 4'd3;
  localparam logic [3:0] TRI_E0   = 4'd4;
  localparam logic [3:0] TRI_E1   = 4'd5;
  localparam logic [3:0] TRI_S0   = 4'd6;
  localparam logic [3:0] TRI_S1   = 4'd7;
  localparam logic [3:0] TRI_W0   = 4'd8;
  localparam logic [3:0] TRI_W1   = 4'd9;
  localparam logic [3:0] TRI_BOT0 = 4'd10;
  localparam logic [3:0] TRI_BOT1 = 4'd11;

  // One vertex pick: which corner, and whether its height is forced to zero.
  typedef struct packed {
    logic       floor;
    logic [1:0] corner;
  } vsel_t;

  typedef struct packed {
    vsel_t a;
    vsel_t b;
    vsel_t c;
  } tri_sel_t;

  function automatic vsel_t vs(input logic floor, input logic [1:0] corner);
    vsel_t v;
    v.floor  = floor;
    v.corner = corner;
    return v;
  endfunction

  // Vertex picks for each triangle slot.
  function automatic tri_sel_t tri_select(input logic [3:0] slot);
    tri_sel_t t;
    case (slot)
      TRI_TOP0: t = '{vs(1'b0, CORNER_SW), vs(1'b0, CORNER_NE), vs(1'b0, CORNER_NW)};
      TRI_TOP1: t = '{vs(1'b0, CORNER_SW), vs(1'b0, CORNER_SE), vs(1'b0, CORNER_NE)};
      TRI_N0:   t = '{vs(1'b0, CORNER_NW), vs(1'b0, CORNER_NE), vs(1'b1, CORNER_NE)};
      TRI_N1:   t = '{vs(1'b1, CORNER_NE), vs(1'b1, CORNER_NW), vs(1'b0, CORNER_NW)};
      TRI_E0:   t = '{vs(1'b0, CORNER_NE), vs(1'b0, CORNER_SE), vs(1'b1, CORNER_SE)};
      TRI_E1:   t = '{vs(1'b1, CORNER_SE), vs(1'b1, CORNER_NE), vs(1'b0, CORNER_NE)};
      TRI_S0:   t = '{vs(1'b0, CORNER_SE), vs(1'b0, CORNER_SW), vs(1'b1, CORNER_SW)};
      TRI_S1:   t = '{vs(1'b1, CORNER_SW), vs(1'b1, CORNER_SE), vs(1'b0, CORNER_SE)};
      TRI_W0:   t = '{vs(1'b0, CORNER_SW), vs(1'b0, CORNER_NW), vs(1'b1, CORNER_NW)};
      TRI_W1:   t = '{vs(1'b1, CORNER_NW), vs(1'b1, CORNER_SW), vs(1'b0, CORNER_SW)};
      TRI_BOT0: t = '{vs(1'b1, CORNER_NW), vs(1'b1, CORNER_SE), vs(1'b1, CORNER_SW)};
      TRI_BOT1: t = '{vs(1'b1, CORNER_NW), vs(1'b1, CORNER_NE), vs(1'b1, CORNER_SE)};
      default:  t = '{vs(1'b1, CORNER_NW), vs(1'b1, CORNER_NE), vs(1'b1, CORNER_SE)};
    endcase
    return t;
  endfunction

endpackage

// ===== design/heightmap_cell_triangulator.sv =====
`timescale 1ns / 1ps

// Load beat: written to the pixel memory when inside the store, no result.
// Mesh beat: nine reads of the pixel memory port, then four corner means on
// one shared divider, then 4 to 12 triangle beats at one per cycle while the
// output is not stalled. A mesh beat outside the image is taken with no
// result. Reset sets the configuration registers to their reset values and
// clears control; the pixel memory is not cleared.
module heightmap_cell_triangulator (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [7:0]                     cell_x,
  input  logic [7:0]                     cell_y,
  input  logic [7:0]                     pixel,
  // Output channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [10:0]             a_x,
  output logic signed [10:0]             a_y,
  output logic [23:0]                    a_z,
  output logic signed [10:0]             b_x,
  output logic signed [10:0]             b_y,
  output logic [23:0]                    b_z,
  output logic signed [10:0]             c_x,
  output logic signed [10:0]             c_y,
  output logic [23:0]                    c_z,
  output logic                           is_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MEAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [3:0] RD_DONE   = 4'd9;
  localparam logic [2:0] MEAN_DONE = 3'd7;
  localparam logic [3:0] TRI_FINAL = 4'(hct_pkg::TRI_COUNT - 1);

  localparam logic [2:0] N_ONE   = 3'd1;
  localparam logic [2:0] N_TWO   = 3'd2;
  localparam logic [2:0] N_THREE = 3'd3;
  localparam logic [2:0] N_FOUR  = 3'd4;

  // Neighbor slots in read order.
  localparam logic [3:0] NB_P = 4'd0;
  localparam logic [3:0] NB_A = 4'd1;
  localparam logic [3:0] NB_B = 4'd2;
  localparam logic [3:0] NB_C = 4'd3;
  localparam logic [3:0] NB_D = 4'd4;
  localparam logic [3:0] NB_E = 4'd5;
  localparam logic [3:0] NB_F = 4'd6;
  localparam logic [3:0] NB_G = 4'd7;
  localparam logic [3:0] NB_H = 4'd8;

  logic [1:0]  state;
  logic [8:0]  image_width;
  logic [8:0]  image_height;
  logic [15:0] z_scale;

  logic [7:0]  cx;
  logic [7:0]  cy;
  logic        n_ok;
  logic        e_ok;
  logic        s_ok;
  logic        w_ok;
  logic [3:0]  rd_cnt;
  logic [2:0]  mean_cnt;
  logic [3:0]  tri_idx;

  logic [hct_pkg::HGT_W-1:0] hgt [0:8];
  logic [hct_pkg::HGT_W-1:0] z_nw;
  logic [hct_pkg::HGT_W-1:0] z_ne;
  logic [hct_pkg::HGT_W-1:0] z_se;
  logic [hct_pkg::HGT_W-1:0] z_sw;
  logic [hct_pkg::SUM_W-1:0] sum_r;
  logic [2:0]                cnt_r;

  logic [10:0] x_lo;
  logic [10:0] x_hi;
  logic [10:0] y_lo;
  logic [10:0] y_hi;

  // Pixel memory.
  logic [7:0]                 mem [0:(1 << hct_pkg::ADDR_W) - 1];
  logic                       mem_we;
  logic [hct_pkg::ADDR_W-1:0] mem_waddr;
  logic [hct_pkg::ADDR_W-1:0] mem_raddr;
  logic [7:0]                 mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= pixel;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Saturated image size and input decode.
  logic [8:0] w_sat;
  logic [8:0] h_sat;
  logic       in_beat;
  logic       in_image;
  logic       in_store;

  assign w_sat = (int'(image_width) > hct_pkg::MAX_WIDTH) ?
                 9'(hct_pkg::MAX_WIDTH) : image_width;
  assign h_sat = (int'(image_height) > hct_pkg::MAX_HEIGHT) ?
                 9'(hct_pkg::MAX_HEIGHT) : image_height;
  assign in_stall = (state != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign in_image = ({1'b0, cell_x} < w_sat) && ({1'b0, cell_y} < h_sat);
  assign in_store = (int'(cell_x) < hct_pkg::MAX_WIDTH) &&
                    (int'(cell_y) < hct_pkg::MAX_HEIGHT);
  assign mem_we    = in_beat && (opcode == hct_pkg::OP_LOAD) && in_store;
  assign mem_waddr = hct_pkg::ADDR_W'(int'(cell_y) * hct_pkg::MAX_WIDTH + int'(cell_x));

  // Neighbor address for the current read slot; wrapped coordinates only
  // occur for neighbors that the border flags mask out later.
  logic [8:0] nb_x;
  logic [8:0] nb_y;

  always_comb begin
    nb_x = {1'b0, cx};
    nb_y = {1'b0, cy};
    case (rd_cnt)
      NB_P: begin end
      NB_A: begin nb_x = nb_x - 9'd1; nb_y = nb_y - 9'd1; end
      NB_B: begin nb_y = nb_y - 9'd1; end
      NB_C: begin nb_x = nb_x + 9'd1; nb_y = nb_y - 9'd1; end
      NB_D: begin nb_x = nb_x + 9'd1; end
      NB_E: begin nb_x = nb_x + 9'd1; nb_y = nb_y + 9'd1; end
      NB_F: begin nb_y = nb_y + 9'd1; end
      NB_G: begin nb_x = nb_x - 9'd1; nb_y = nb_y + 9'd1; end
      NB_H: begin nb_x = nb_x - 9'd1; end
      default: begin end
    endcase
  end

  assign mem_raddr = hct_pkg::ADDR_W'(int'(nb_y) * hct_pkg::MAX_WIDTH + int'(nb_x));

  // Height of the pixel returned by the memory.
  logic [hct_pkg::HGT_W-1:0] rd_hgt;
  logic [3:0]                rd_slot;

  assign rd_hgt  = hct_pkg::HGT_W'(256) + ({8'd0, z_scale} * {16'd0, mem_rdata});
  assign rd_slot = rd_cnt - 4'd1;

  // Corner sum: the cell height plus the in-image neighbors at that corner.
  logic [hct_pkg::SUM_W-1:0] sum_next;
  logic [2:0]                cnt_next;
  logic [hct_pkg::HGT_W-1:0] h1;
  logic [hct_pkg::HGT_W-1:0] h2;
  logic [hct_pkg::HGT_W-1:0] h3;
  logic                      u1;
  logic                      u2;
  logic                      u3;

  always_comb begin
    case (mean_cnt[2:1])
      hct_pkg::CORNER_NW: begin
        h1 = hgt[NB_A]; u1 = n_ok && w_ok;
        h2 = hgt[NB_B]; u2 = n_ok;
        h3 = hgt[NB_H]; u3 = w_ok;
      end
      hct_pkg::CORNER_NE: begin
        h1 = hgt[NB_B]; u1 = n_ok;
        h2 = hgt[NB_C]; u2 = n_ok && e_ok;
        h3 = hgt[NB_D]; u3 = e_ok;
      end
      hct_pkg::CORNER_SE: begin
        h1 = hgt[NB_D]; u1 = e_ok;
        h2 = hgt[NB_E]; u2 = s_ok && e_ok;
        h3 = hgt[NB_F]; u3 = s_ok;
      end
      default: begin
        h1 = hgt[NB_H]; u1 = w_ok;
        h2 = hgt[NB_F]; u2 = s_ok;
        h3 = hgt[NB_G]; u3 = s_ok && w_ok;
      end
    endcase
    sum_next = hct_pkg::SUM_W'(hgt[NB_P])
             + (u1 ? hct_pkg::SUM_W'(h1) : '0)
             + (u2 ? hct_pkg::SUM_W'(h2) : '0)
             + (u3 ? hct_pkg::SUM_W'(h3) : '0);
    cnt_next = N_ONE + {2'b0, u1} + {2'b0, u2} + {2'b0, u3};
  end

  // Truncated mean of the registered sum.
  logic [hct_pkg::SUM_W+hct_pkg::DIV3_SHIFT-1:0] div3_prod;
  logic [hct_pkg::HGT_W-1:0]                     mean_q;

  assign div3_prod = {{hct_pkg::DIV3_SHIFT{1'b0}}, sum_r} *
                     {{hct_pkg::SUM_W{1'b0}}, hct_pkg::DIV3_MUL};

  always_comb begin
    case (cnt_r)
      N_TWO:   mean_q = sum_r[hct_pkg::HGT_W:1];
      N_THREE: mean_q = div3_prod[hct_pkg::DIV3_SHIFT +: hct_pkg::HGT_W];
      N_FOUR:  mean_q = sum_r[hct_pkg::HGT_W+1:2];
      default: mean_q = sum_r[hct_pkg::HGT_W-1:0];
    endcase
  end

  // Triangles this cell emits, and the next one after the current slot.
  logic [hct_pkg::TRI_COUNT-1:0] tri_en;
  logic [3:0]                    tri_nxt;

  assign tri_en = {2'b11, !w_ok, !w_ok, !s_ok, !s_ok, !e_ok, !e_ok,
                   !n_ok, !n_ok, 2'b11};

  always_comb begin
    tri_nxt = TRI_FINAL;
    for (int i = hct_pkg::TRI_COUNT - 2; i >= 1; i--) begin
      if ((4'(i) > tri_idx) && tri_en[i]) begin
        tri_nxt = 4'(i);
      end
    end
  end

  // Vertex lookup for the current triangle.
  hct_pkg::tri_sel_t sel;

  assign sel = hct_pkg::tri_select(tri_idx);

  function automatic logic [10:0] vx(input hct_pkg::vsel_t v, input logic [10:0] lo,
                                     input logic [10:0] hi);
    return ((v.corner == hct_pkg::CORNER_NW) || (v.corner == hct_pkg::CORNER_SW)) ? lo : hi;
  endfunction

  function automatic logic [10:0] vy(input hct_pkg::vsel_t v, input logic [10:0] lo,
                                     input logic [10:0] hi);
    return ((v.corner == hct_pkg::CORNER_NW) || (v.corner == hct_pkg::CORNER_NE)) ? hi : lo;
  endfunction

  function automatic logic [23:0] vz(input hct_pkg::vsel_t v,
                                     input logic [23:0] znw, input logic [23:0] zne,
                                     input logic [23:0] zse, input logic [23:0] zsw);
    logic [23:0] z;
    case (v.corner)
      hct_pkg::CORNER_NW: z = znw;
      hct_pkg::CORNER_NE: z = zne;
      hct_pkg::CORNER_SE: z = zse;
      default:            z = zsw;
    endcase
    return v.floor ? 24'd0 : z;
  endfunction

  logic emit_load;

  assign emit_load = (state == S_EMIT) && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
      z_scale      <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hct_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[8:0];
        hct_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[8:0];
        hct_pkg::REG_Z_SCALE:      z_scale      <= cfg_data;
        default: begin end
      endcase
    end
  end

  // Sequencer: read nine pixels, form four corner means, emit triangles.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_cnt    <= '0;
      mean_cnt  <= '0;
      tri_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_beat && (opcode == hct_pkg::OP_MESH) && in_image) begin
            state  <= S_READ;
            rd_cnt <= '0;
          end
        end
        S_READ: begin
          rd_cnt <= rd_cnt + 4'd1;
          if (rd_cnt == RD_DONE) begin
            state    <= S_MEAN;
            mean_cnt <= '0;
          end
        end
        S_MEAN: begin
          mean_cnt <= mean_cnt + 3'd1;
          if (mean_cnt == MEAN_DONE) begin
            state   <= S_EMIT;
            tri_idx <= hct_pkg::TRI_TOP0;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            tri_idx <= tri_nxt;
            if (tri_idx == TRI_FINAL) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Cell registers, captured heights and corner means.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cx   <= cell_x;
      cy   <= cell_y;
      n_ok <= (cell_y != 8'd0);
      w_ok <= (cell_x != 8'd0);
      e_ok <= (({1'b0, cell_x} + 9'd1) != w_sat);
      s_ok <= (({1'b0, cell_y} + 9'd1) != h_sat);
      x_lo <= {2'b00, cell_x, 1'b0} - 11'd1;
      x_hi <= {2'b00, cell_x, 1'b0} + 11'd1;
      y_lo <= ({1'b0, h_sat, 1'b0} - {2'b00, cell_y, 1'b0}) - 11'd1;
      y_hi <= ({1'b0, h_sat, 1'b0} - {2'b00, cell_y, 1'b0}) + 11'd1;
    end
    if ((state == S_READ) && (rd_cnt != NB_P)) begin
      hgt[rd_slot] <= rd_hgt;
    end
    if (state == S_MEAN) begin
      if (!mean_cnt[0]) begin
        sum_r <= sum_next;
        cnt_r <= cnt_next;
      end else begin
        case (mean_cnt[2:1])
          hct_pkg::CORNER_NW: z_nw <= mean_q;
          hct_pkg::CORNER_NE: z_ne <= mean_q;
          hct_pkg::CORNER_SE: z_se <= mean_q;
          default:            z_sw <= mean_q;
        endcase
      end
    end
  end

  // Output beat registers.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      a_x     <= vx(sel.a, x_lo, x_hi);
      a_y     <= vy(sel.a, y_lo, y_hi);
      a_z     <= vz(sel.a, z_nw, z_ne, z_se, z_sw);
      b_x     <= vx(sel.b, x_lo, x_hi);
      b_y     <= vy(sel.b, y_lo, y_hi);
      b_z     <= vz(sel.b, z_nw, z_ne, z_se, z_sw);
      c_x     <= vx(sel.c, x_lo, x_hi);
      c_y     <= vy(sel.c, y_lo, y_hi);
      c_z     <= vz(sel.c, z_nw, z_ne, z_se, z_sw);
      is_last <= (tri_idx == TRI_FINAL);
    end
  end

`ifndef SYNTHESIS
  // Pixel writes never overlap a cell's neighbor reads.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE))
    else $error("pixel write outside idle");

  // Only triangles enabled for this cell's borders are emitted.
  a_tri_enabled: assert property (@(posedge clk) disable iff (rst)
    emit_load |-> tri_en[tri_idx])
    else $error("disabled triangle emitted");

  // Corner means start only after all nine heights are captured.
  a_reads_done: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MEAN) && ($past(state) == S_READ)) |-> ($past(rd_cnt) == RD_DONE))
    else $error("mean started before reads finished");

  // The final beat of a cell carries the last mark and returns to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_load && (tri_idx == TRI_FINAL)) |=> (is_last && (state == S_IDLE)))
    else $error("final triangle not marked");
`endif

endmodule
